### design/fbpa_pkg.sv
package fbpa_pkg;

	localparam int ADDR_IO_W   = 32;
	localparam int SIZE_W      = 16;
	localparam int COUNT_W     = 7;
	localparam int INDEX_IO_W  = 6;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int EFF_SIZE_W  = SIZE_W + 1;
	localparam int SIZE_GRAIN  = 4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_DIV,
		S_EVAL,
		S_SCAN,
		S_MUL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                clr_step;
		logic                load;
		logic                prep;
		logic                div_init;
		logic                div_step;
		logic                scan_init;
		logic                scan_issue;
		logic                mark_set;
		logic                mark_clr;
		logic                mul;
		logic                set_code;
		logic [STATUS_W-1:0] code;
		logic                res_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_free;
		logic count_zero;
		logic pre_bad;
		logic div_last;
		logic rem_zero;
		logic found;
		logic empty;
		logic out_free;
	} sts_t;

endpackage

### design/fbpa_ctrl.sv
module fbpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  fbpa_pkg::sts_t  sts,
	output fbpa_pkg::cmd_t  cmd
);
	import fbpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (sts.op_free && sts.pre_bad) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_BADADDR;
					state_d      = S_OUT;
				end else if (!sts.op_free && sts.count_zero) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_EMPTY;
					state_d      = S_OUT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.op_free) begin
					cmd.set_code = 1'b1;
					if (sts.rem_zero) begin
						cmd.code     = ST_OK;
						cmd.mark_clr = 1'b1;
					end else begin
						cmd.code = ST_BADADDR;
					end
					state_d = S_OUT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.found) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_OK;
					cmd.mark_set = 1'b1;
					state_d      = S_MUL;
				end else if (sts.empty) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_EMPTY;
					state_d      = S_OUT;
				end else begin
					cmd.scan_issue = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

### design/fbpa_dp.sv
module fbpa_dp #(
	parameter int MAX_BLOCKS = 64,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              op,
	input  logic [fbpa_pkg::ADDR_IO_W-1:0]    free_address,
	input  logic                              out_ready,
	input  fbpa_pkg::cmd_t                    cmd,
	output fbpa_pkg::sts_t                    sts,
	output logic                              out_valid,
	output logic [fbpa_pkg::STATUS_W-1:0]     status,
	output logic [fbpa_pkg::ADDR_IO_W-1:0]    block_address,
	output logic [fbpa_pkg::INDEX_IO_W-1:0]   block_index
);
	import fbpa_pkg::*;

	localparam int W   = (ADDR_WIDTH < ADDR_IO_W) ? ADDR_WIDTH : ADDR_IO_W;
	localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int KW  = (CW > 1) ? $clog2(CW) : 1;
	localparam int EW  = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int RW  = EFF_SIZE_W + CW;
	localparam int PW  = IW + EFF_SIZE_W;
	localparam int XW  = (W > RW) ? W : RW;
	localparam int AXW = (W > PW) ? W : PW;
	localparam int IXW = (IW > INDEX_IO_W) ? IW : INDEX_IO_W;

	// configuration
	logic [ADDR_IO_W-1:0] base_q;
	logic [SIZE_W-1:0]    size_q;
	logic [COUNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= SIZE_W'(SIZE_GRAIN);
			count_q <= COUNT_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data[ADDR_IO_W-1:0];
				CFG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
				CFG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [W-1:0]          base_w;
	logic [EFF_SIZE_W-1:0] size_rnd;
	logic [EFF_SIZE_W-1:0] eff_size;
	logic [EW-1:0]         cnt_x;
	logic [EW-1:0]         cnt_sat;
	logic [CW-1:0]         eff_cnt;
	logic [CW-1:0]         cnt_m1;
	logic [RW-1:0]         lim_prod;

	assign base_w   = base_q[W-1:0];
	assign size_rnd = ({1'b0, size_q} + EFF_SIZE_W'(SIZE_GRAIN - 1))
	                  & ~EFF_SIZE_W'(SIZE_GRAIN - 1);
	assign eff_size = (size_rnd == '0) ? EFF_SIZE_W'(SIZE_GRAIN) : size_rnd;
	assign cnt_x    = EW'(count_q);
	assign cnt_sat  = (cnt_x > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS) : cnt_x;
	assign eff_cnt  = cnt_sat[CW-1:0];
	assign cnt_m1   = eff_cnt - CW'(1);
	assign lim_prod = RW'(eff_cnt) * RW'(eff_size);

	// request and address check
	logic          op_q;
	logic [W-1:0]  faddr_q;
	logic [W-1:0]  off_q;
	logic          addr_bad_q;
	logic [RW-1:0] lim_q;
	logic [XW-1:0] off_x;

	assign off_x = XW'(off_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			faddr_q <= free_address[W-1:0];
		end
		if (cmd.prep) begin
			off_q      <= faddr_q - base_w;
			addr_bad_q <= (faddr_q == '0) || (faddr_q < base_w);
			lim_q      <= lim_prod;
		end
	end

	// shared restoring divider, one quotient bit per cycle
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [CW-1:0] quo_q;
	logic [KW-1:0] k_q;
	logic [RW-1:0] dvs_sh;
	logic [IW-1:0] search_q;

	assign dvs_sh = dvs_q << k_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			if (op_q == OP_FREE) begin
				rem_q <= off_x[RW-1:0];
				dvs_q <= RW'(eff_size);
			end else begin
				rem_q <= RW'(search_q);
				dvs_q <= RW'(eff_cnt);
			end
			quo_q <= '0;
			k_q   <= KW'(CW - 1);
		end else if (cmd.div_step) begin
			if (rem_q >= dvs_sh) begin
				rem_q     <= rem_q - dvs_sh;
				quo_q[k_q] <= 1'b1;
			end
			k_q <= k_q - KW'(1);
		end
	end

	// mark store, clearing sweep and next-fit scan
	logic          marks_mem [MAX_BLOCKS];
	logic [IW-1:0] clr_idx_q;
	logic [IW-1:0] probe_q;
	logic [CW-1:0] issued_q;
	logic          issue_ok;
	logic          rd_vld_s1;
	logic          rd_last_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_data_s1;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          wr_data;
	logic [IW-1:0] idx_q;

	assign issue_ok = issued_q != eff_cnt;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_idx_q;
		wr_data = 1'b0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.mark_set) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
			wr_data = 1'b1;
		end else if (cmd.mark_clr) begin
			wr_en   = 1'b1;
			wr_addr = quo_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			marks_mem[wr_addr] <= wr_data;
		end
		if (cmd.scan_issue && issue_ok) begin
			rd_data_s1 <= marks_mem[probe_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			rd_vld_s1  <= 1'b0;
			search_q   <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + IW'(1);
			end
			if (cmd.scan_init) begin
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan_issue) begin
				rd_vld_s1 <= issue_ok;
			end
			if (cmd.mark_set) begin
				search_q <= rd_idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			probe_q  <= rem_q[IW-1:0];
			issued_q <= '0;
		end else if (cmd.scan_issue && issue_ok) begin
			rd_idx_s1  <= probe_q;
			rd_last_s1 <= issued_q == cnt_m1;
			probe_q    <= (probe_q == cnt_m1[IW-1:0]) ? '0 : probe_q + IW'(1);
			issued_q   <= issued_q + CW'(1);
		end
		if (cmd.mark_set) begin
			idx_q <= rd_idx_s1;
		end else if (cmd.mark_clr) begin
			idx_q <= quo_q[IW-1:0];
		end
	end

	// result
	logic [PW-1:0]         prod_q;
	logic [STATUS_W-1:0]   code_q;
	logic [AXW-1:0]        prod_x;
	logic [W-1:0]          sum_w;
	logic [IXW-1:0]        idx_x;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ADDR_IO_W-1:0]  addr_q;
	logic [INDEX_IO_W-1:0] index_q;

	assign prod_x = AXW'(prod_q);
	assign sum_w  = base_w + prod_x[W-1:0];
	assign idx_x  = IXW'(idx_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= idx_q * eff_size;
		end
		if (cmd.set_code) begin
			code_q <= cmd.code;
		end
		if (cmd.res_load) begin
			status_q <= code_q;
			addr_q   <= (code_q == ST_OK && op_q == OP_ALLOC) ? ADDR_IO_W'(sum_w) : '0;
			index_q  <= (code_q == ST_OK) ? idx_x[INDEX_IO_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = addr_q;
	assign block_index   = index_q;

	assign sts.clr_last   = clr_idx_q == IW'(MAX_BLOCKS - 1);
	assign sts.op_free    = op_q == OP_FREE;
	assign sts.count_zero = eff_cnt == '0;
	assign sts.pre_bad    = addr_bad_q || (off_x >= XW'(lim_q));
	assign sts.div_last   = k_q == '0;
	assign sts.rem_zero   = rem_q == '0;
	assign sts.found      = rd_vld_s1 && !rd_data_s1;
	assign sts.empty      = rd_vld_s1 && rd_last_s1 && rd_data_s1;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

### design/fixed_block_pool_allocator.sv
// Steps: prepare, check, divide over C = clog2(MAX_BLOCKS+1) bits (7 by default),
//   evaluate; an allocate then scans next fit and, if a block is free, multiplies.
//   A free failing the range check or an allocate with no blocks goes to the output.
// Throughput: one item at a time, next beat taken the cycle after the result is loaded;
//   the divider steps and the one-probe-per-cycle mark store set the pace.
// Reset: a sweep sets every mark in the store to free, in_ready low; config is taken.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 64,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [fbpa_pkg::ADDR_IO_W-1:0]    free_address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fbpa_pkg::STATUS_W-1:0]     status,
	output logic [fbpa_pkg::ADDR_IO_W-1:0]    block_address,
	output logic [fbpa_pkg::INDEX_IO_W-1:0]   block_index
);
	import fbpa_pkg::*;

	// The controller sequences each request: address check, a shared restoring
	// divider (free offset by block size, or search start modulo block count),
	// the next-fit scan of the mark store for an allocate, and the load of the output register.
	cmd_t cmd;
	sts_t sts;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath owns the configuration registers, the mark store, the divider
	// and the output register that holds a result until its beat is taken.
	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.free_address  (free_address),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.status        (status),
		.block_address (block_address),
		.block_index   (block_index)
	);

	// One request in flight: an accepted beat keeps the input closed next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a request is in flight");

	// A failed request carries neither an address nor an index.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> block_address == '0 && block_index == '0)
		else $error("failed request returned a nonzero address or index");

	// A block is claimed only when the scan has seen it free, and the scan stops there.
	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_set |-> sts.found && !cmd.scan_issue)
		else $error("block claimed without a free probe");

	// The output register is reloaded only once its beat has gone.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result overwritten before it was taken");

endmodule

### bench/pool_reply_checker.sv
`timescale 1ns / 100ps
module pool_reply_checker #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            op,
	input  logic [fbpa_pkg::ADDR_IO_W-1:0]  free_address,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [fbpa_pkg::STATUS_W-1:0]   status,
	input  logic [fbpa_pkg::ADDR_IO_W-1:0]  block_address,
	input  logic [fbpa_pkg::INDEX_IO_W-1:0] block_index,
	output int                              mismatches,
	output int                              outstanding
);
	import fbpa_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [ADDR_IO_W-1:0]  addr;
		logic [INDEX_IO_W-1:0] index;
	} pool_reply_t;

	logic [ADDR_IO_W-1:0] pool_base;
	logic [SIZE_W-1:0]    pool_size;
	logic [COUNT_W-1:0]   pool_count;
	logic                 held [MAX_BLOCKS];
	int unsigned          next_start;
	pool_reply_t          pending_replies[$];
	int                   errs;

	// Size rounds up to the grain; zero behaves as one grain.
	function automatic int unsigned grain_size();
		int unsigned s;
		s = ((int'(pool_size) + SIZE_GRAIN - 1) / SIZE_GRAIN) * SIZE_GRAIN;
		return (s == 0) ? SIZE_GRAIN : s;
	endfunction

	function automatic pool_reply_t predict_reply(input logic req_op,
			input logic [ADDR_IO_W-1:0] faddr);
		pool_reply_t     r;
		int unsigned     blocks, step, slot, i;
		longint unsigned off;
		r = '{status: ST_EMPTY, addr: '0, index: '0};
		blocks = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
		step = grain_size();
		if (req_op == OP_ALLOC) begin
			// Next fit: start at the last block handed out, wrap over the live count.
			for (i = 0; i < blocks; i++) begin
				slot = (next_start + i) % blocks;
				if (!held[slot]) begin
					held[slot] = 1'b1;
					next_start = slot;
					r.status = ST_OK;
					r.addr = pool_base + ADDR_IO_W'(slot * step);
					r.index = INDEX_IO_W'(slot);
					break;
				end
			end
		end else begin
			r.status = ST_BADADDR;
			if (faddr != '0 && faddr >= pool_base) begin
				off = faddr - pool_base;
				if (off % step == 0 && off / step < blocks) begin
					slot = off / step;
					held[slot] = 1'b0;
					r.status = ST_OK;
					r.index = INDEX_IO_W'(slot);
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [ADDR_IO_W-1:0] want,
			input logic [ADDR_IO_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		pool_reply_t want;
		if (!arst_n) begin
			pool_base = '0;
			pool_size = SIZE_W'(SIZE_GRAIN);
			pool_count = COUNT_W'(MAX_BLOCKS);
			foreach (held[i]) held[i] = 1'b0;
			next_start = 0;
			pending_replies.delete();
			errs = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE:  pool_base = cfg_data[ADDR_IO_W-1:0];
					CFG_SIZE:  pool_size = cfg_data[SIZE_W-1:0];
					CFG_COUNT: pool_count = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			// Retire the result beat before predicting a new request taken on this edge.
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected result, status %0d address %h index %0d",
						$time, status, block_address, block_index);
					errs++;
				end else begin
					want = pending_replies.pop_front();
					check_field("status", ADDR_IO_W'(want.status), ADDR_IO_W'(status));
					check_field("block_address", want.addr, block_address);
					check_field("block_index", ADDR_IO_W'(want.index), ADDR_IO_W'(block_index));
				end
			end
			if (in_valid && in_ready)
				pending_replies.push_back(predict_reply(op, free_address));
		end
		mismatches <= errs;
		outstanding <= pending_replies.size();
	end

endmodule

### bench/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 100ps
module tb_fixed_block_pool_allocator;
	import fbpa_pkg::*;

	localparam int POOL_DEPTH  = 64;
	// Slowest beat: reset sweep, a full scan, a long receiver stall and a long
	// sender gap all stacked; the limit is several times that.
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 125;
	localparam int PHASES      = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  op = OP_ALLOC;
	logic [ADDR_IO_W-1:0]  free_address = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [ADDR_IO_W-1:0]  block_address;
	logic [INDEX_IO_W-1:0] block_index;

	int reply_errors;
	int replies_owed;

	// Stimulus-side view of the pool, only used to aim frees at real blocks.
	logic [ADDR_IO_W-1:0] gen_base = '0;
	int unsigned          gen_step = SIZE_GRAIN;
	int unsigned          gen_blocks = POOL_DEPTH;

	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	int hold_off = 0;
	int quiet_cycles = 0;
	int n_alloc = 0;
	int n_free = 0;
	int n_settings = 0;

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_DEPTH),
		.ADDR_WIDTH(ADDR_IO_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.block_address(block_address),
		.block_index(block_index)
	);

	pool_reply_checker #(
		.MAX_BLOCKS(POOL_DEPTH)
	) reply_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.block_address(block_address),
		.block_index(block_index),
		.mismatches(reply_errors),
		.outstanding(replies_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Pause length: mostly a few cycles, now and then a long one.
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 12);
		return $urandom_range(30, 80);
	endfunction

	// Receiver: drop out_ready for random stretches, whether or not a beat is waiting,
	// so the stalls land on every stage of the block's work.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_ready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
			hold_off = pick_pause() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: any accepted beat or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, QUIET_LIMIT, replies_owed);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one request beat; called at a rising edge and returns at one.
	// With no gap the next call keeps valid high and just swaps the payload.
	task automatic issue(input logic req_op, input logic [ADDR_IO_W-1:0] addr);
		int gap;
		in_valid <= 1'b1;
		op <= req_op;
		free_address <= addr;
		do @(posedge clk); while (!in_ready);
		if (req_op == OP_ALLOC)
			n_alloc++;
		else
			n_free++;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every result beat is back. Wait for the next edge first so the
	// outstanding count reflects a request taken on the current edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Reprogram the pool only when it is idle. Upper data bits are junk on purpose.
	task automatic set_pool(input logic [ADDR_IO_W-1:0] base, input logic [SIZE_W-1:0] size,
			input logic [COUNT_W-1:0] count);
		wait_idle();
		write_reg(CFG_BASE, base);
		write_reg(CFG_SIZE, {16'($urandom), size});
		write_reg(CFG_COUNT, {25'($urandom), count});
		cfg_we <= 1'b0;
		gen_base = base;
		gen_step = ((int'(size) + SIZE_GRAIN - 1) / SIZE_GRAIN) * SIZE_GRAIN;
		if (gen_step == 0)
			gen_step = SIZE_GRAIN;
		gen_blocks = (count > POOL_DEPTH) ? POOL_DEPTH : count;
		n_settings++;
	endtask

	// Mostly frees of real blocks; the rest past the end, misaligned, below base,
	// zero, or pure noise.
	function automatic logic [ADDR_IO_W-1:0] pick_free_address();
		int unsigned r, k;
		r = $urandom_range(0, 99);
		k = (gen_blocks > 0) ? $urandom_range(0, gen_blocks - 1) : 0;
		if (r < 70)
			return gen_base + k * gen_step;
		if (r < 78)
			return gen_base + (gen_blocks + $urandom_range(0, 3)) * gen_step;
		if (r < 86)
			return gen_base + k * gen_step + $urandom_range(1, gen_step - 1);
		if (r < 91)
			return gen_base - 4 * $urandom_range(1, 1024);
		if (r < 95)
			return '0;
		return $urandom;
	endfunction

	initial begin
		int phase, n, alloc_pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, on the reset settings first: base 0, 4-byte blocks, 64 blocks.
		issue(OP_FREE, 32'h0000_0000);     // zero address: reject
		issue(OP_ALLOC, $urandom);         // block 0
		issue(OP_ALLOC, $urandom);         // block 1
		issue(OP_FREE, 32'h0000_0004);     // release block 1
		issue(OP_FREE, 32'h0000_0004);     // double free goes through unnoticed
		issue(OP_FREE, 32'h0000_0006);     // not on a block boundary
		issue(OP_FREE, 32'h0000_0100);     // one past the last block
		issue(OP_FREE, 32'hFFFF_FFFF);     // all ones
		issue(OP_ALLOC, $urandom);         // search resumes at block 1

		// Odd size rounds up to 64 KiB, count saturates, addresses wrap past 2^32.
		set_pool(32'hFFFF_0000, 16'hFFFF, 7'd100);
		issue(OP_ALLOC, $urandom);         // block 2, address wraps to low memory
		issue(OP_FREE, 32'h0001_0000);     // that wrapped address sits below base
		issue(OP_FREE, 32'hFFFF_0000);     // block 0 back
		issue(OP_FREE, 32'hFFFE_FFFC);     // just below base

		// Size zero acts as one grain; three blocks with marks kept from before.
		set_pool(32'h0000_1000, 16'd0, 7'd3);
		issue(OP_ALLOC, $urandom);         // search wraps to block 0
		issue(OP_ALLOC, $urandom);         // pool full
		issue(OP_FREE, 32'h0000_1004);     // block 1 back
		issue(OP_ALLOC, $urandom);         // and taken again

		// Empty pool, with a size that needs rounding.
		set_pool(32'h0000_2000, 16'd5, 7'd0);
		issue(OP_ALLOC, $urandom);
		issue(OP_FREE, 32'h0000_2000);

		// Random part: one pool setting per phase, extremes among them. Large counts
		// come before small ones so the search start often lands past the new count.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_pool('0, 16'd4, 7'd64);
				1: set_pool(32'hFFFF_FFFC, 16'd65532, 7'd1);
				2: set_pool($urandom, 16'(4 * $urandom_range(1, 16383)),
					7'($urandom_range(1, POOL_DEPTH)));
				3: set_pool($urandom, 16'($urandom), 7'($urandom));
				4: set_pool(32'h1000_0000, 16'd65532, 7'd64);
				5: set_pool($urandom, 16'(4 * $urandom_range(1, 64)), 7'd8);
				6: set_pool($urandom, 16'($urandom_range(0, 15)), 7'd2);
				default: set_pool($urandom, 16'hFFFF, 7'd127);
			endcase
			// Vary the mix so pools fill up in some phases and drain in others.
			case (phase % 3)
				0: alloc_pct = 70;
				1: alloc_pct = 50;
				default: alloc_pct = 30;
			endcase
			// One phase runs flat out on both sides.
			tx_gaps = (phase != 4);
			rx_stalls <= (phase != 4);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_idle();
				if ($urandom_range(0, 99) < alloc_pct)
					issue(OP_ALLOC, $urandom);
				else
					issue(OP_FREE, pick_free_address());
			end
		end

		// Drain, then give the block time to show any stray result beat.
		wait_idle();
		repeat (100) @(posedge clk);
		$display("Covered %0d allocations and %0d frees over %0d pool settings,",
			n_alloc, n_free, n_settings + 1);
		$display("with random sender gaps and receiver stalls, and %0d mismatches.",
			reply_errors);
		if (reply_errors == 0 && replies_owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
design/fbpa_pkg.sv
design/fbpa_ctrl.sv
design/fbpa_dp.sv
design/fixed_block_pool_allocator.sv
bench/pool_reply_checker.sv
bench/tb_fixed_block_pool_allocator.sv
